[sv/mau_pkg.sv]
package mau_pkg;

    localparam logic [30:0] MOD_RESET = 31'd998244353;
    localparam int          DIV_STEPS = 64;
    localparam int          CNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_INV = 3'd4,
        KIND_POW = 3'd5,
        KIND_NEG = 3'd6,
        KIND_RED = 3'd7
    } kind_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RX,
        S_RXW,
        S_RY,
        S_RYW,
        S_DISP,
        S_MD,
        S_MDW,
        S_SVW,
        S_EUC,
        S_EUCW,
        S_EUW,
        S_DM,
        S_PCHK,
        S_PRD,
        S_PRW,
        S_PSQ,
        S_PBD,
        S_PBW,
        S_OUT
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ZERO,
        CMD_DIV_A,
        CMD_DIV_B,
        CMD_DIV_PROD,
        CMD_DIV_SV,
        CMD_DIV_EU,
        CMD_DIV_EUC,
        CMD_SET_X,
        CMD_SET_Y,
        CMD_SET_R,
        CMD_SET_R_SIGNED,
        CMD_SET_BASE,
        CMD_ADD,
        CMD_SUB,
        CMD_NEG,
        CMD_MUL_XY,
        CMD_MUL_XR,
        CMD_MUL_RB,
        CMD_MUL_BB,
        CMD_POW_INIT,
        CMD_EUC_INIT_X,
        CMD_EUC_INIT_Y,
        CMD_EUC_UPD
    } cmd_t;

    typedef struct packed {
        logic  div_done;
        logic  m_small;
        logic  eb_zero;
        logic  e_zero;
        logic  e_lsb;
        kind_t kind;
    } status_t;

endpackage

[sv/mau_div.sv]
module mau_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [30:0] divisor,
    output logic        done,
    output logic [63:0] quotient,
    output logic [30:0] remainder
);

    logic [mau_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [30:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [30:0] dvs_reg, dvs_next;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        ge;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = mau_pkg::CNT_W'(mau_pkg::DIV_STEPS);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = ge ? diff[30:0] : trial[30:0];
            quo_next = {quo_reg[62:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = (cnt_reg == '0);
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[sv/mau_dp.sv]
module mau_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mau_pkg::cmd_t         cmd,
    input  logic                  cfg_we,
    input  logic [30:0]           cfg_data,
    input  logic [2:0]            kind,
    input  logic [30:0]           operand_a,
    input  logic [30:0]           operand_b,
    input  logic [63:0]           exponent,
    input  logic signed [63:0]    signed_value,
    output mau_pkg::status_t      status,
    output logic [30:0]           residue
);

    logic [30:0] mod_reg;
    logic [2:0]  kind_reg;
    logic [30:0] a_reg, b_reg;
    logic [63:0] e_reg;
    logic [63:0] sv_reg;
    logic [30:0] x_reg, y_reg, r_reg, base_reg;
    logic [61:0] prod_reg;
    logic [30:0] ea_reg, eb_reg;
    logic signed [32:0] eu_reg, ev_reg;
    logic        neg_reg;

    logic        div_start;
    logic [63:0] div_dividend;
    logic [30:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quo;
    logic [30:0] div_rem;

    logic [63:0] sv_mag;
    logic [32:0] eu_mag;
    logic [30:0] mul_a, mul_b;
    logic [61:0] mul_p;
    logic [31:0] sum, dif, mod_ext;
    logic [30:0] add_res, sub_res, neg_res, signed_res;
    logic signed [64:0] euc_p;
    logic [33:0] ev_wide;

    mau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign mod_ext = {1'b0, mod_reg};
    assign sv_mag  = sv_reg[63] ? (64'd0 - sv_reg) : sv_reg;
    assign eu_mag  = eu_reg[32] ? (33'd0 - eu_reg) : eu_reg;

    // single conditional correction
    assign sum     = {1'b0, x_reg} + {1'b0, y_reg};
    assign add_res = (sum >= mod_ext) ? 31'(sum - mod_ext) : sum[30:0];
    assign dif     = {1'b0, x_reg} + mod_ext - {1'b0, y_reg};
    assign sub_res = (dif >= mod_ext) ? 31'(dif - mod_ext) : dif[30:0];
    assign neg_res = (x_reg == '0) ? '0 : 31'(mod_reg - x_reg);
    assign signed_res = (neg_reg && div_rem != '0) ? 31'(mod_reg - div_rem) : div_rem;

    // Euclid coefficient update, value fits 33 bits signed
    assign euc_p   = $signed({1'b0, div_quo[30:0]}) * ev_reg;
    assign ev_wide = {eu_reg[32], eu_reg} - euc_p[33:0];

    always_comb
    begin
        unique case (cmd)
            mau_pkg::CMD_MUL_XY:
            begin
                mul_a = x_reg;
                mul_b = y_reg;
            end
            mau_pkg::CMD_MUL_XR:
            begin
                mul_a = x_reg;
                mul_b = r_reg;
            end
            mau_pkg::CMD_MUL_RB:
            begin
                mul_a = r_reg;
                mul_b = base_reg;
            end
            default:
            begin
                mul_a = base_reg;
                mul_b = base_reg;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = mod_reg;
        unique case (cmd)
            mau_pkg::CMD_DIV_A:
            begin
                div_start    = 1'b1;
                div_dividend = {33'd0, a_reg};
            end
            mau_pkg::CMD_DIV_B:
            begin
                div_start    = 1'b1;
                div_dividend = {33'd0, b_reg};
            end
            mau_pkg::CMD_DIV_PROD:
            begin
                div_start    = 1'b1;
                div_dividend = {2'd0, prod_reg};
            end
            mau_pkg::CMD_DIV_SV:
            begin
                div_start    = 1'b1;
                div_dividend = sv_mag;
            end
            mau_pkg::CMD_DIV_EU:
            begin
                div_start    = 1'b1;
                div_dividend = {31'd0, eu_mag};
            end
            mau_pkg::CMD_DIV_EUC:
            begin
                div_start    = 1'b1;
                div_dividend = {33'd0, ea_reg};
                div_divisor  = eb_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg <= mau_pkg::MOD_RESET;
        end
        else if (cfg_we)
        begin
            mod_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd)
            mau_pkg::CMD_LOAD:
            begin
                kind_reg <= kind;
                a_reg    <= operand_a;
                b_reg    <= operand_b;
                e_reg    <= exponent;
                sv_reg   <= signed_value;
            end
            mau_pkg::CMD_ZERO:         r_reg <= '0;
            mau_pkg::CMD_DIV_SV:       neg_reg <= sv_reg[63];
            mau_pkg::CMD_DIV_EU:       neg_reg <= eu_reg[32];
            mau_pkg::CMD_SET_X:        x_reg <= div_rem;
            mau_pkg::CMD_SET_Y:        y_reg <= div_rem;
            mau_pkg::CMD_SET_R:        r_reg <= div_rem;
            mau_pkg::CMD_SET_R_SIGNED: r_reg <= signed_res;
            mau_pkg::CMD_SET_BASE:
            begin
                base_reg <= div_rem;
                e_reg    <= {1'b0, e_reg[63:1]};
            end
            mau_pkg::CMD_ADD:          r_reg <= add_res;
            mau_pkg::CMD_SUB:          r_reg <= sub_res;
            mau_pkg::CMD_NEG:          r_reg <= neg_res;
            mau_pkg::CMD_MUL_XY,
            mau_pkg::CMD_MUL_XR,
            mau_pkg::CMD_MUL_RB,
            mau_pkg::CMD_MUL_BB:       prod_reg <= mul_p;
            mau_pkg::CMD_POW_INIT:
            begin
                r_reg    <= 31'd1;
                base_reg <= x_reg;
            end
            mau_pkg::CMD_EUC_INIT_X,
            mau_pkg::CMD_EUC_INIT_Y:
            begin
                ea_reg <= (cmd == mau_pkg::CMD_EUC_INIT_X) ? x_reg : y_reg;
                eb_reg <= mod_reg;
                eu_reg <= 33'sd1;
                ev_reg <= 33'sd0;
            end
            mau_pkg::CMD_EUC_UPD:
            begin
                ea_reg <= eb_reg;
                eb_reg <= div_rem;
                eu_reg <= ev_reg;
                ev_reg <= $signed(ev_wide[32:0]);
            end
            default:
            begin
            end
        endcase
    end

    assign status.div_done = div_done;
    assign status.m_small  = (mod_reg < 31'd2);
    assign status.eb_zero  = (eb_reg == '0);
    assign status.e_zero   = (e_reg == '0);
    assign status.e_lsb    = e_reg[0];
    assign status.kind     = mau_pkg::kind_t'(kind_reg);
    assign residue         = r_reg;

endmodule

[sv/mau_ctrl.sv]
module mau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_stall,
    input  mau_pkg::status_t  status,
    output mau_pkg::cmd_t     cmd,
    output logic              in_stall,
    output logic              out_valid
);

    mau_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mau_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mau_pkg::S_IDLE: if (in_valid) state_next = mau_pkg::S_RX;
            mau_pkg::S_RX:   state_next = status.m_small ? mau_pkg::S_OUT : mau_pkg::S_RXW;
            mau_pkg::S_RXW:  if (status.div_done) state_next = mau_pkg::S_RY;
            mau_pkg::S_RY:   state_next = mau_pkg::S_RYW;
            mau_pkg::S_RYW:  if (status.div_done) state_next = mau_pkg::S_DISP;
            mau_pkg::S_DISP:
            begin
                unique case (status.kind)
                    mau_pkg::KIND_MUL:                   state_next = mau_pkg::S_MD;
                    mau_pkg::KIND_DIV, mau_pkg::KIND_INV: state_next = mau_pkg::S_EUC;
                    mau_pkg::KIND_POW:                   state_next = mau_pkg::S_PCHK;
                    mau_pkg::KIND_RED:                   state_next = mau_pkg::S_SVW;
                    default:                             state_next = mau_pkg::S_OUT;
                endcase
            end
            mau_pkg::S_MD:   state_next = mau_pkg::S_MDW;
            mau_pkg::S_MDW:  if (status.div_done) state_next = mau_pkg::S_OUT;
            mau_pkg::S_SVW:  if (status.div_done) state_next = mau_pkg::S_OUT;
            mau_pkg::S_EUC:  state_next = status.eb_zero ? mau_pkg::S_EUW : mau_pkg::S_EUCW;
            mau_pkg::S_EUCW: if (status.div_done) state_next = mau_pkg::S_EUC;
            mau_pkg::S_EUW:
            begin
                if (status.div_done)
                    state_next = (status.kind == mau_pkg::KIND_DIV) ? mau_pkg::S_DM
                                                                   : mau_pkg::S_OUT;
            end
            mau_pkg::S_DM:   state_next = mau_pkg::S_MD;
            mau_pkg::S_PCHK:
            begin
                if (status.e_zero)
                    state_next = mau_pkg::S_OUT;
                else
                    state_next = status.e_lsb ? mau_pkg::S_PRD : mau_pkg::S_PBD;
            end
            mau_pkg::S_PRD:  state_next = mau_pkg::S_PRW;
            mau_pkg::S_PRW:  if (status.div_done) state_next = mau_pkg::S_PSQ;
            mau_pkg::S_PSQ:  state_next = mau_pkg::S_PBD;
            mau_pkg::S_PBD:  state_next = mau_pkg::S_PBW;
            mau_pkg::S_PBW:  if (status.div_done) state_next = mau_pkg::S_PCHK;
            mau_pkg::S_OUT:  if (!out_stall) state_next = mau_pkg::S_IDLE;
            default:         state_next = mau_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = mau_pkg::CMD_NONE;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        unique case (state_reg)
            mau_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd      = mau_pkg::CMD_LOAD;
            end
            mau_pkg::S_RX:   cmd = status.m_small ? mau_pkg::CMD_ZERO : mau_pkg::CMD_DIV_A;
            mau_pkg::S_RXW:  if (status.div_done) cmd = mau_pkg::CMD_SET_X;
            mau_pkg::S_RY:   cmd = mau_pkg::CMD_DIV_B;
            mau_pkg::S_RYW:  if (status.div_done) cmd = mau_pkg::CMD_SET_Y;
            mau_pkg::S_DISP:
            begin
                unique case (status.kind)
                    mau_pkg::KIND_ADD: cmd = mau_pkg::CMD_ADD;
                    mau_pkg::KIND_SUB: cmd = mau_pkg::CMD_SUB;
                    mau_pkg::KIND_NEG: cmd = mau_pkg::CMD_NEG;
                    mau_pkg::KIND_MUL: cmd = mau_pkg::CMD_MUL_XY;
                    mau_pkg::KIND_DIV: cmd = mau_pkg::CMD_EUC_INIT_Y;
                    mau_pkg::KIND_INV: cmd = mau_pkg::CMD_EUC_INIT_X;
                    mau_pkg::KIND_POW: cmd = mau_pkg::CMD_POW_INIT;
                    default:           cmd = mau_pkg::CMD_DIV_SV;
                endcase
            end
            mau_pkg::S_MD:   cmd = mau_pkg::CMD_DIV_PROD;
            mau_pkg::S_MDW:  if (status.div_done) cmd = mau_pkg::CMD_SET_R;
            mau_pkg::S_SVW:  if (status.div_done) cmd = mau_pkg::CMD_SET_R_SIGNED;
            mau_pkg::S_EUC:  cmd = status.eb_zero ? mau_pkg::CMD_DIV_EU : mau_pkg::CMD_DIV_EUC;
            mau_pkg::S_EUCW: if (status.div_done) cmd = mau_pkg::CMD_EUC_UPD;
            mau_pkg::S_EUW:  if (status.div_done) cmd = mau_pkg::CMD_SET_R_SIGNED;
            mau_pkg::S_DM:   cmd = mau_pkg::CMD_MUL_XR;
            mau_pkg::S_PCHK:
            begin
                if (!status.e_zero)
                    cmd = status.e_lsb ? mau_pkg::CMD_MUL_RB : mau_pkg::CMD_MUL_BB;
            end
            mau_pkg::S_PRD:  cmd = mau_pkg::CMD_DIV_PROD;
            mau_pkg::S_PRW:  if (status.div_done) cmd = mau_pkg::CMD_SET_R;
            mau_pkg::S_PSQ:  cmd = mau_pkg::CMD_MUL_BB;
            mau_pkg::S_PBD:  cmd = mau_pkg::CMD_DIV_PROD;
            mau_pkg::S_PBW:  if (status.div_done) cmd = mau_pkg::CMD_SET_BASE;
            mau_pkg::S_OUT:  out_valid = 1'b1;
            default:         cmd = mau_pkg::CMD_NONE;
        endcase
    end

endmodule

[sv/modular_arithmetic_unit.sv]
// Modular arithmetic unit: one request in, one residue out, over the modulus
// register (reset 998244353, written through cfg_we/cfg_data; the user must
// write it only while idle, which the block itself does not enforce).
// A single request is worked at a time; in_stall is low only when idle.
// All reductions go through one shared 64-step restoring divider. Each
// request first reduces both operands, then goes on by kind:
//   add, sub, negate:     result formed from the reduced operands
//   multiply:             product reduced
//   reduce signed value:  magnitude reduced, sign applied
//   power:                square-and-multiply over the exponent bits up to
//                         the top set bit
//   inverse:              Euclid steps
//   divide:               inverse, then multiply and reduce
// out_stall holds the residue until it is taken. A modulus below two gives
// residue 0 with no reduction. Inverse of zero and division by zero give 0.
module modular_arithmetic_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [30:0]        operand_a,
    input  logic [30:0]        operand_b,
    input  logic [63:0]        exponent,
    input  logic signed [63:0] signed_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [30:0]        residue
);

    mau_pkg::cmd_t    cmd;
    mau_pkg::status_t status;

    // controller: sequences reductions, Euclid and square-and-multiply
    mau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    // datapath: operand registers, shared multiplier, divider, result register
    mau_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .kind         (kind),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .exponent     (exponent),
        .signed_value (signed_value),
        .status       (status),
        .residue      (residue)
    );

`ifndef SYNTHESIS
    a_small_mod_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status.m_small) |-> (residue == '0))
        else $error("nonzero residue with modulus below two");

    a_accept_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result presented right after request accepted");

    a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!out_valid && !in_stall))
        else $error("not idle after result taken");

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request side open while result pending");
`endif

endmodule
